// ===== hdl/ssp_pkg.sv =====
// Shared constants, codes and types for the small-graph shortest-path block.
package ssp_pkg;

  localparam int NODES_DEF   = 16;
  localparam int DEGREE_DEF  = 4;
  localparam int MAX_RESULTS = 16;
  localparam logic [7:0] DIST_INF = 8'hFF;

  // Function codes carried by an input item.
  typedef enum logic [1:0] {
    FUNC_SLOT   = 2'd0,
    FUNC_ENABLE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_ADJ_RD,
    ST_ADJ_EV,
    ST_RELAX,
    ST_GOAL_RD,
    ST_GOAL_EV,
    ST_CH_WR,
    ST_CH_EV,
    ST_EM_RD,
    ST_EM_EV,
    ST_OUT
  } state_t;

  // Write request for the node enable flags.
  typedef struct packed {
    logic       we;
    logic [5:0] idx;
    logic       val;
  } en_wr_t;

endpackage

// ===== hdl/ssp_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module ssp_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ssp_engine.sv =====
// Sequencer: item decode, Dijkstra rounds over the memories, path backtrack and emission.
module ssp_engine import ssp_pkg::*; #(
  parameter int NODES  = NODES_DEF,
  parameter int DEGREE = DEGREE_DEF,
  parameter int NW = $clog2(NODES),
  parameter int AW = $clog2(NODES * DEGREE),
  parameter int SW = NW + 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       func,
  input  logic [5:0]       node,
  input  logic [1:0]       slot,
  input  logic [3:0]       neighbour,
  input  logic             edge_present,
  input  logic [7:0]       weight,
  input  logic             enable_flag,
  input  logic [5:0]       goal_node,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             found,
  output logic [3:0]       path_node,
  output logic [7:0]       distance,
  output logic             last,
  input  logic [NODES-1:0] en,
  output en_wr_t           en_wr,
  output logic             adj_we,
  output logic [AW-1:0]    adj_waddr,
  output logic [12:0]      adj_wdata,
  output logic [AW-1:0]    adj_raddr,
  input  logic [12:0]      adj_rdata,
  output logic             sc_we,
  output logic [NW-1:0]    sc_waddr,
  output logic [SW-1:0]    sc_wdata,
  output logic [NW-1:0]    sc_raddr,
  input  logic [SW-1:0]    sc_rdata,
  output logic             ch_we,
  output logic [NW-1:0]    ch_waddr,
  output logic [NW-1:0]    ch_wdata,
  output logic [NW-1:0]    ch_raddr,
  input  logic [NW-1:0]    ch_rdata
);

  localparam int KW = (DEGREE > 1) ? $clog2(DEGREE) : 1;
  localparam logic [6:0]  NODES_L  = 7'(NODES);
  localparam logic [NW:0] NODES_J  = (NW + 1)'(NODES);
  localparam logic [AW:0] CLR_LAST = (AW + 1)'(NODES * DEGREE - 1);
  localparam logic [KW-1:0] K_LAST = KW'(DEGREE - 1);

  state_t state, state_next;
  logic [AW:0]   clr, clr_next;
  logic [NW-1:0] start_n, start_n_next, goal_n, goal_n_next;
  logic [NW:0]   j, j_next;
  logic          pend, pend_next;
  logic [NW-1:0] pidx, pidx_next;
  logic [7:0]    lowest, lowest_next;
  logic          ufound, ufound_next;
  logic [NW-1:0] u, u_next;
  logic          upv, upv_next;
  logic [NW-1:0] upred, upred_next;
  logic [KW-1:0] k, k_next;
  logic [NW-1:0] cur, cur_next;
  logic [NW:0]   len, len_next;
  logic [NW:0]   idx, idx_next;
  logic [7:0]    dgoal, dgoal_next;
  logic          out_valid_next, found_next, last_next;
  logic [3:0]    path_node_next;
  logic [7:0]    distance_next;

  // Scratch entry fields: visited, predecessor valid, predecessor, distance.
  logic [7:0]    s_dist;
  logic [NW-1:0] s_pred;
  logic          s_pv, s_vis;
  logic          e_present;
  logic [6:0]    e_v;
  logic [7:0]    e_w;
  logic [8:0]    sum;
  logic          in_acc;
  logic [6:0]    node7, goal7;
  logic [7:0]    len8;

  assign s_dist    = sc_rdata[7:0];
  assign s_pred    = sc_rdata[NW+7:8];
  assign s_pv      = sc_rdata[NW+8];
  assign s_vis     = sc_rdata[NW+9];
  assign e_present = adj_rdata[12];
  assign e_v       = 7'(adj_rdata[11:8]);
  assign e_w       = adj_rdata[7:0];
  assign sum       = {1'b0, lowest} + {1'b0, dgoal};
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign node7     = 7'(node);
  assign goal7     = 7'(goal_node);
  assign len8      = 8'(len);

  // Register update.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      out_valid <= out_valid_next;
      pend      <= pend_next;
    end
    start_n   <= start_n_next;
    goal_n    <= goal_n_next;
    j         <= j_next;
    pidx      <= pidx_next;
    lowest    <= lowest_next;
    ufound    <= ufound_next;
    u         <= u_next;
    upv       <= upv_next;
    upred     <= upred_next;
    k         <= k_next;
    cur       <= cur_next;
    len       <= len_next;
    idx       <= idx_next;
    dgoal     <= dgoal_next;
    found     <= found_next;
    last      <= last_next;
    path_node <= path_node_next;
    distance  <= distance_next;
  end

  // Next state, memory accesses and result register loads.
  always_comb begin
    state_next     = state;
    clr_next       = clr;
    start_n_next   = start_n;
    goal_n_next    = goal_n;
    j_next         = j;
    pend_next      = 1'b0;
    pidx_next      = pidx;
    lowest_next    = lowest;
    ufound_next    = ufound;
    u_next         = u;
    upv_next       = upv;
    upred_next     = upred;
    k_next         = k;
    cur_next       = cur;
    len_next       = len;
    idx_next       = idx;
    dgoal_next     = dgoal;
    out_valid_next = out_valid;
    found_next     = found;
    last_next      = last;
    path_node_next = path_node;
    distance_next  = distance;
    en_wr          = '0;
    adj_we         = 1'b0;
    adj_waddr      = '0;
    adj_wdata      = '0;
    adj_raddr      = AW'(u * DEGREE + k);
    sc_we          = 1'b0;
    sc_waddr       = '0;
    sc_wdata       = '0;
    sc_raddr       = j[NW-1:0];
    ch_we          = 1'b0;
    ch_waddr       = len[NW-1:0];
    ch_wdata       = cur;
    ch_raddr       = idx[NW-1:0];

    unique case (state)
      // Empty every neighbour slot after reset.
      ST_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr[AW-1:0];
        clr_next  = clr + 1'b1;
        if (clr == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end

      // Take one item and decode it.
      ST_IDLE: begin
        if (in_acc) begin
          unique case (func_t'(func))
            FUNC_SLOT: begin
              if (node7 < NODES_L && 32'(slot) < DEGREE) begin
                adj_we    = 1'b1;
                adj_waddr = AW'(node[NW-1:0] * DEGREE + slot);
                adj_wdata = {edge_present, neighbour, weight};
              end
            end
            FUNC_ENABLE: begin
              en_wr.we  = (node7 < NODES_L);
              en_wr.idx = node;
              en_wr.val = enable_flag;
            end
            FUNC_QUERY: begin
              start_n_next = node[NW-1:0];
              goal_n_next  = goal_node[NW-1:0];
              if (node7 >= NODES_L || goal7 >= NODES_L ||
                  !en[node[NW-1:0]] || !en[goal_node[NW-1:0]]) begin
                out_valid_next = 1'b1;
                found_next     = 1'b0;
                path_node_next = '0;
                distance_next  = '0;
                last_next      = 1'b1;
                state_next     = ST_OUT;
              end else if (node == goal_node) begin
                out_valid_next = 1'b1;
                found_next     = 1'b1;
                path_node_next = node[3:0];
                distance_next  = '0;
                last_next      = 1'b1;
                state_next     = ST_OUT;
              end else begin
                j_next     = '0;
                state_next = ST_INIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Reset the scratch entries of every node.
      ST_INIT: begin
        sc_we    = 1'b1;
        sc_waddr = j[NW-1:0];
        sc_wdata = {1'b0, 1'b0, {NW{1'b0}},
                    (j[NW-1:0] == start_n) ? 8'd0 : DIST_INF};
        j_next   = j + 1'b1;
        if (j + 1'b1 == NODES_J) begin
          j_next      = '0;
          lowest_next = DIST_INF;
          ufound_next = 1'b0;
          state_next  = ST_SCAN;
        end
      end

      // Stream through the scratch memory for the closest open node.
      ST_SCAN: begin
        if (pend && !s_vis && en[pidx] && s_dist < lowest) begin
          lowest_next = s_dist;
          ufound_next = 1'b1;
          u_next      = pidx;
          upv_next    = s_pv;
          upred_next  = s_pred;
        end
        if (j != NODES_J) begin
          sc_raddr  = j[NW-1:0];
          pend_next = 1'b1;
          pidx_next = j[NW-1:0];
          j_next    = j + 1'b1;
        end else begin
          state_next = ST_SCAN_END;
        end
      end

      // Settle the chosen node, or move on to the backtrack.
      ST_SCAN_END: begin
        if (ufound) begin
          sc_we      = 1'b1;
          sc_waddr   = u;
          sc_wdata   = {1'b1, upv, upred, lowest};
          k_next     = '0;
          state_next = ST_ADJ_RD;
        end else begin
          state_next = ST_GOAL_RD;
        end
      end

      ST_ADJ_RD: begin
        adj_raddr  = AW'(u * DEGREE + k);
        state_next = ST_ADJ_EV;
      end

      // Inspect one neighbour slot of the settled node.
      ST_ADJ_EV: begin
        dgoal_next = e_w;
        if (!e_present) begin
          j_next      = '0;
          lowest_next = DIST_INF;
          ufound_next = 1'b0;
          state_next  = ST_SCAN;
        end else if (e_v < NODES_L && en[e_v[NW-1:0]]) begin
          sc_raddr   = e_v[NW-1:0];
          cur_next   = e_v[NW-1:0];
          state_next = ST_RELAX;
        end else if (k == K_LAST) begin
          j_next      = '0;
          lowest_next = DIST_INF;
          ufound_next = 1'b0;
          state_next  = ST_SCAN;
        end else begin
          k_next     = k + 1'b1;
          state_next = ST_ADJ_RD;
        end
      end

      // Relax the neighbour when the new sum is strictly smaller.
      ST_RELAX: begin
        if (!s_vis && sum < {1'b0, s_dist}) begin
          sc_we    = 1'b1;
          sc_waddr = cur;
          sc_wdata = {1'b0, 1'b1, u, sum[7:0]};
        end
        if (k == K_LAST) begin
          j_next      = '0;
          lowest_next = DIST_INF;
          ufound_next = 1'b0;
          state_next  = ST_SCAN;
        end else begin
          k_next     = k + 1'b1;
          state_next = ST_ADJ_RD;
        end
      end

      ST_GOAL_RD: begin
        sc_raddr   = goal_n;
        state_next = ST_GOAL_EV;
      end

      // Check reachability of the goal.
      ST_GOAL_EV: begin
        if (s_dist == DIST_INF) begin
          out_valid_next = 1'b1;
          found_next     = 1'b0;
          path_node_next = '0;
          distance_next  = '0;
          last_next      = 1'b1;
          state_next     = ST_OUT;
        end else begin
          dgoal_next = s_dist;
          cur_next   = goal_n;
          len_next   = '0;
          state_next = ST_CH_WR;
        end
      end

      // Record the chain from goal back to start.
      ST_CH_WR: begin
        ch_we      = 1'b1;
        ch_waddr   = len[NW-1:0];
        ch_wdata   = cur;
        sc_raddr   = cur;
        len_next   = len + 1'b1;
        state_next = ST_CH_EV;
      end

      ST_CH_EV: begin
        if (!s_pv || len == NODES_J) begin
          if (len8 > 8'(MAX_RESULTS)) begin
            idx_next = (NW + 1)'(MAX_RESULTS - 1);
          end else begin
            idx_next = len - 1'b1;
          end
          state_next = ST_EM_RD;
        end else begin
          cur_next   = s_pred;
          state_next = ST_CH_WR;
        end
      end

      ST_EM_RD: begin
        ch_raddr   = idx[NW-1:0];
        state_next = ST_EM_EV;
      end

      // Load one path node into the result register.
      ST_EM_EV: begin
        out_valid_next = 1'b1;
        found_next     = 1'b1;
        path_node_next = 4'(ch_rdata);
        last_next      = (idx == '0);
        distance_next  = (idx == '0) ? dgoal : 8'd0;
        state_next     = ST_OUT;
      end

      // Hold the result until it is taken.
      ST_OUT: begin
        if (out_ready) begin
          out_valid_next = 1'b0;
          if (last) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx - 1'b1;
            state_next = ST_EM_RD;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/small_graph_shortest_path.sv =====
// A query's running time is set by its scan rounds; each round reads the scratch entry of
// every node. Slot and enable writes are made as the item is accepted, and one item is
// worked on at a time. Each path result waits in the output register until taken; the next
// is read from the chain memory only after that. After reset the adjacency memory is
// cleared with in_ready low; all nodes come out of reset enabled.
module small_graph_shortest_path import ssp_pkg::*; #(
  parameter int NODES  = NODES_DEF,
  parameter int DEGREE = DEGREE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [5:0] node,
  input  logic [1:0] slot,
  input  logic [3:0] neighbour,
  input  logic       edge_present,
  input  logic [7:0] weight,
  input  logic       enable_flag,
  input  logic [5:0] goal_node,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       found,
  output logic [3:0] path_node,
  output logic [7:0] distance,
  output logic       last
);

  localparam int NW = $clog2(NODES);
  localparam int AW = $clog2(NODES * DEGREE);
  localparam int SW = NW + 10;

  logic [NODES-1:0] en;
  en_wr_t           en_wr;
  logic             adj_we, sc_we, ch_we;
  logic [AW-1:0]    adj_waddr, adj_raddr;
  logic [12:0]      adj_wdata, adj_rdata;
  logic [NW-1:0]    sc_waddr, sc_raddr, ch_waddr, ch_raddr, ch_wdata, ch_rdata;
  logic [SW-1:0]    sc_wdata, sc_rdata;

  // Node enable flags, all set by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      en <= '1;
    end else if (en_wr.we) begin
      en[en_wr.idx[NW-1:0]] <= en_wr.val;
    end
  end

  // Neighbour slots: present, neighbour index, weight.
  ssp_ram #(.W(13), .D(NODES * DEGREE), .AW(AW)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  // Per-query scratch: visited, predecessor and best distance.
  ssp_ram #(.W(SW), .D(NODES), .AW(NW)) u_scratch (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
    .raddr(sc_raddr), .rdata(sc_rdata)
  );

  // Path chain from goal back to start.
  ssp_ram #(.W(NW), .D(NODES), .AW(NW)) u_chain (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );

  ssp_engine #(.NODES(NODES), .DEGREE(DEGREE)) u_engine (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .node(node), .slot(slot), .neighbour(neighbour),
    .edge_present(edge_present), .weight(weight), .enable_flag(enable_flag),
    .goal_node(goal_node),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .path_node(path_node), .distance(distance), .last(last),
    .en(en), .en_wr(en_wr),
    .adj_we(adj_we), .adj_waddr(adj_waddr), .adj_wdata(adj_wdata),
    .adj_raddr(adj_raddr), .adj_rdata(adj_rdata),
    .sc_we(sc_we), .sc_waddr(sc_waddr), .sc_wdata(sc_wdata),
    .sc_raddr(sc_raddr), .sc_rdata(sc_rdata),
    .ch_we(ch_we), .ch_waddr(ch_waddr), .ch_wdata(ch_wdata),
    .ch_raddr(ch_raddr), .ch_rdata(ch_rdata)
  );

endmodule

// ===== hdl/ssp_checker.sv =====
// Port-level checks for the shortest-path block, bound to its top level.
module ssp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       found,
  input logic [3:0] path_node,
  input logic [7:0] distance,
  input logic       last
);

  // A failure result is always the only result of its query.
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last && distance == 8'd0 && path_node == 4'd0)
    else $error("failure item not alone");

  // Only the final item of a path carries a distance.
  a_mid_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> distance == 8'd0 && found)
    else $error("distance on a middle item");

  // No new item is taken while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while result pending");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(path_node) && $stable(last))
    else $error("result changed while stalled");

endmodule

bind small_graph_shortest_path ssp_checker u_ssp_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .found(found), .path_node(path_node),
  .distance(distance), .last(last)
);

// ===== tb/path_checker.sv =====
// Checker for the shortest-path block: mirrors the graph tables, predicts each query's path and compares results.
module path_checker import ssp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] func,
  input  logic [5:0] node,
  input  logic [1:0] slot,
  input  logic [3:0] neighbour,
  input  logic       edge_present,
  input  logic [7:0] weight,
  input  logic       enable_flag,
  input  logic [5:0] goal_node,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       found,
  input  logic [3:0] path_node,
  input  logic [7:0] distance,
  input  logic       last,
  output int         fail_count,
  output int         pending,
  output int         queries_seen,
  output int         hops_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = NODES_DEF;
  localparam int D = DEGREE_DEF;

  typedef struct packed {
    logic       found;
    logic [3:0] path_node;
    logic [7:0] distance;
    logic       last;
  } hop_t;

  logic       adj_present [N*D];
  logic [3:0] adj_index [N*D];
  logic [7:0] adj_cost [N*D];
  logic       usable [N];
  hop_t       expected_hops[$];

  // Run Dijkstra on the mirrored graph and queue the expected hops.
  task automatic predict_path(input int unsigned src, input int unsigned dst);
    logic [7:0] cost_to [N];
    int         prev [N];
    logic       done [N];
    int         chain[$];
    int         u, v, lowest, sum, cur, first;
    if (src >= N || dst >= N || !usable[src] || !usable[dst]) begin
      expected_hops.push_back('{1'b0, 4'd0, 8'd0, 1'b1});
      return;
    end
    if (src == dst) begin
      expected_hops.push_back('{1'b1, src[3:0], 8'd0, 1'b1});
      return;
    end
    for (int i = 0; i < N; i++) begin
      cost_to[i] = DIST_INF;
      prev[i] = -1;
      done[i] = 1'b0;
    end
    cost_to[src] = 8'd0;
    for (int r = 0; r < N; r++) begin
      u = N;
      lowest = DIST_INF;
      for (int j = 0; j < N; j++) begin
        if (!done[j] && usable[j] && cost_to[j] < lowest) begin
          lowest = cost_to[j];
          u = j;
        end
      end
      if (u >= N) break;
      done[u] = 1'b1;
      // A list ends at the first empty slot.
      for (int k = 0; k < D; k++) begin
        if (!adj_present[u*D+k]) break;
        v = adj_index[u*D+k];
        if (v >= N || !usable[v] || done[v]) continue;
        sum = cost_to[u] + adj_cost[u*D+k];
        if (cost_to[u] != DIST_INF && sum < cost_to[v]) begin
          cost_to[v] = sum[7:0];
          prev[v] = u;
        end
      end
    end
    if (cost_to[dst] == DIST_INF) begin
      expected_hops.push_back('{1'b0, 4'd0, 8'd0, 1'b1});
      return;
    end
    cur = dst;
    while (chain.size() < N) begin
      chain.push_back(cur);
      if (prev[cur] < 0) break;
      cur = prev[cur];
    end
    first = chain.size() > MAX_RESULTS ? MAX_RESULTS : chain.size();
    for (int i = first; i > 0; i--) begin
      if (i == 1) expected_hops.push_back('{1'b1, chain[0][3:0], cost_to[dst], 1'b1});
      else expected_hops.push_back('{1'b1, chain[i-1][3:0], 8'd0, 1'b0});
    end
  endtask

  assign pending = expected_hops.size();

  // Track accepted items and compare every accepted result.
  always @(posedge clk) begin
    hop_t want;
    if (rst) begin
      for (int i = 0; i < N*D; i++) begin
        adj_present[i] = 1'b0;
        adj_index[i] = 4'd0;
        adj_cost[i] = 8'd0;
      end
      for (int i = 0; i < N; i++) usable[i] = 1'b1;
      expected_hops.delete();
      fail_count = 0;
      queries_seen = 0;
      hops_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        hops_seen++;
        if (expected_hops.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: found=%0d node=%0d dist=%0d last=%0d",
                     found, path_node, distance, last);
        end else begin
          want = expected_hops.pop_front();
          if (want.found !== found || want.path_node !== path_node ||
              want.distance !== distance || want.last !== last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: want f=%0d n=%0d d=%0d l=%0d, got f=%0d n=%0d d=%0d l=%0d",
                       want.found, want.path_node, want.distance, want.last,
                       found, path_node, distance, last);
          end
        end
      end
      if (in_valid && in_ready) begin
        case (func_t'(func))
          FUNC_SLOT: if (node < N && slot < D) begin
            adj_present[node*D+slot] = edge_present;
            adj_index[node*D+slot] = neighbour;
            adj_cost[node*D+slot] = weight;
          end
          FUNC_ENABLE: if (node < N) usable[node] = enable_flag;
          FUNC_QUERY: begin
            queries_seen++;
            predict_path(node, goal_node);
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
// Top level of the shortest-path testbench: drives items with random gaps and gives the verdict.
module testbench import ssp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] func = FUNC_NONE;
  logic [5:0] node = '0;
  logic [1:0] slot = '0;
  logic [3:0] neighbour = '0;
  logic       edge_present = 1'b0;
  logic [7:0] weight = '0;
  logic       enable_flag = 1'b0;
  logic [5:0] goal_node = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       found;
  logic [3:0] path_node;
  logic [7:0] distance;
  logic       last;
  int         fail_count, pending, queries_seen, hops_seen;
  int         idle_cycles = 0;
  int         stall_phase = 0;
  logic       stimulus_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  small_graph_shortest_path i_dut (.*);

  path_checker i_checker (.*);

  // Receiver stalls on a rolling pattern with random dropouts.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[7]) out_ready <= 1'b1;
    else out_ready <= (stall_phase % 5 != 3) && ($urandom_range(0, 3) != 0);
  end

  // Watchdog on cycles without any accepted item or result.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired");
      $display("TB_ERROR");
      $finish;
    end
  end

  int burst_left = 0;

  // Present one item and hold it until accepted; gaps come between bursts.
  task automatic send_item(input logic [1:0] f, input logic [5:0] n, input logic [1:0] s,
                           input logic [3:0] nb, input logic p, input logic [7:0] w,
                           input logic e, input logic [5:0] g);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    func <= f;
    node <= n;
    slot <= s;
    neighbour <= nb;
    edge_present <= p;
    weight <= w;
    enable_flag <= e;
    goal_node <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic write_edge(input int n, input int s, input int nb, input int w);
    send_item(FUNC_SLOT, n, s, nb, 1'b1, w, 1'b0, 6'd0);
  endtask

  task automatic ask_path(input int a, input int b);
    send_item(FUNC_QUERY, a, $urandom, $urandom, $urandom, $urandom, $urandom, b);
  endtask

  int a, b;

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: chain 0-1-2 with cheap detour, extremes and failure cases.
    write_edge(0, 0, 1, 255);
    write_edge(0, 1, 2, 10);
    write_edge(2, 0, 1, 5);
    write_edge(1, 0, 3, 254);
    send_item(FUNC_SLOT, 2, 1, 15, 1'b0, 8'd0, 1'b0, 6'd0);
    send_item(FUNC_SLOT, 63, 3, 4, 1'b1, 8'd1, 1'b1, 6'd63);
    ask_path(0, 1);
    ask_path(0, 3);
    ask_path(5, 5);
    ask_path(0, 63);
    ask_path(63, 0);
    ask_path(3, 0);
    send_item(FUNC_ENABLE, 2, 0, 0, 0, 0, 1'b0, 0);
    ask_path(0, 1);
    ask_path(2, 2);
    send_item(FUNC_ENABLE, 2, 0, 0, 0, 0, 1'b1, 0);
    send_item(FUNC_ENABLE, 40, 0, 0, 0, 0, 1'b0, 0);
    send_item(FUNC_NONE, 0, 3, 15, 1'b1, 8'hFF, 1'b1, 6'd63);
    // Present slot naming a disabled node is skipped, not a list end.
    write_edge(4, 0, 15, 1);
    write_edge(4, 1, 6, 7);
    send_item(FUNC_ENABLE, 15, 0, 0, 0, 0, 1'b0, 0);
    ask_path(4, 6);
    ask_path(4, 15);
    send_item(FUNC_ENABLE, 15, 0, 0, 0, 0, 1'b1, 0);

    // Random: mostly graph edits and in-range queries, some noise.
    for (int i = 0; i < 86; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_item(FUNC_SLOT, $urandom_range(0, 17), $urandom, $urandom,
                              $urandom_range(0, 5) != 0, $urandom, $urandom, $urandom);
        4: send_item(FUNC_ENABLE, $urandom_range(0, 17), $urandom, $urandom, $urandom,
                     $urandom, $urandom_range(0, 3) != 0, $urandom);
        5: send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        default: begin
          a = $urandom_range(0, 15);
          b = $urandom_range(0, 16) == 16 ? $urandom_range(0, 63) : $urandom_range(0, 15);
          ask_path(a, b);
        end
      endcase
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("Ran %0d queries, checked %0d path results over random graph edits.",
             queries_seen, hops_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/ssp_pkg.sv
hdl/ssp_ram.sv
hdl/ssp_engine.sv
hdl/small_graph_shortest_path.sv
hdl/ssp_checker.sv
tb/path_checker.sv
tb/testbench.sv
